[rtl/core/mss_pkg.sv]
// Mash schedule sequencer package: widths, stage codes, register map and
// the transaction, result and configuration structs.
// No dependencies; every other file in rtl/core uses it.
package mss_pkg;

   localparam int SecW    = 23;
   localparam int TempW   = 12;
   localparam int StageW  = 4;
   localparam int SpeedW  = 6;
   localparam int DegW    = 8;
   localparam int MinW    = 8;
   localparam int SetW    = 16;
   localparam int VentW   = 2;
   localparam int NumSets = 6;
   localparam int SetIdxW = 3;
   localparam int AddrW   = 5;
   localparam int DataW   = 32;
   localparam int RegIdxW = 3;
   localparam int ProdW   = 14;

   localparam logic [SpeedW-1:0] SpeedFull = 6'd60;
   localparam logic [SpeedW-1:0] SpeedHalf = 6'd30;
   localparam logic [SpeedW-1:0] SpeedOff  = 6'd0;

   localparam logic [SecW:0] PulseFirstEnd   = 24'd5;
   localparam logic [SecW:0] PulseSecondOpen = 24'd10;
   localparam logic [SecW:0] PulseSecondEnd  = 24'd15;

   localparam logic [SecW-1:0]  SecMax      = {SecW{1'b1}};
   localparam logic [VentW-1:0] VentMax     = 2'd3;
   localparam logic [VentW-1:0] VentsNeeded = 2'd2;

   typedef enum logic [StageW-1:0] {
      ST_IDLE    = 4'd0,
      ST_MASHIN  = 4'd1,
      ST_GRAIN   = 4'd2,
      ST_REST1   = 4'd3,
      ST_REST2   = 4'd4,
      ST_REST3   = 4'd5,
      ST_REST4   = 4'd6,
      ST_MASHOUT = 4'd7,
      ST_BOIL    = 4'd8,
      ST_DONE    = 4'd9
   } stage_type;

   typedef enum logic [RegIdxW-1:0] {
      REG_MASHIN  = 3'd0,
      REG_REST1   = 3'd1,
      REG_REST2   = 3'd2,
      REG_REST3   = 3'd3,
      REG_REST4   = 3'd4,
      REG_MASHOUT = 3'd5,
      REG_BOIL    = 3'd6
   } reg_type;

   localparam logic [SetIdxW-1:0] SET_REST1 = 3'd0;
   localparam logic [SetIdxW-1:0] SET_BOIL  = 3'd5;

   typedef struct packed {
      logic [DegW-1:0]                mashin_target;
      logic [NumSets-1:0][SetW-1:0]   setting;
   } cfg_type;

   typedef struct packed {
      logic [SecW-1:0]          now_seconds;
      logic signed [TempW-1:0]  kettle_temp;
      logic                     water_ready;
      logic                     grain_added;
      logic                     mashout_done;
   } item_type;

   typedef struct packed {
      logic [StageW-1:0] stage_out;
      logic              heat_enable;
      logic              pump_enable;
      logic [SpeedW-1:0] pump_speed_out;
      logic [DegW-1:0]   target_out;
   } result_type;

   function automatic logic [DegW-1:0] deg_of(input logic [SetW-1:0] s);
      return s[SetW-1 -: DegW];
   endfunction

   function automatic logic [MinW-1:0] min_of(input logic [SetW-1:0] s);
      return s[MinW-1:0];
   endfunction

endpackage

[rtl/core/mss_if.sv]
// Valid/ready channel interfaces for the sample and result transactions.
// Depends on mss_pkg for field widths.
interface mss_req_if;
   logic                              valid;
   logic                              ready;
   logic [mss_pkg::SecW-1:0]          now_seconds;
   logic signed [mss_pkg::TempW-1:0]  kettle_temp;
   logic                              water_ready;
   logic                              grain_added;
   logic                              mashout_done;

   modport source (output valid, now_seconds, kettle_temp, water_ready, grain_added,
                   mashout_done, input ready);
   modport sink   (input valid, now_seconds, kettle_temp, water_ready, grain_added,
                   mashout_done, output ready);
endinterface

interface mss_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mss_pkg::StageW-1:0]    stage_out;
   logic                          heat_enable;
   logic                          pump_enable;
   logic [mss_pkg::SpeedW-1:0]    pump_speed_out;
   logic [mss_pkg::DegW-1:0]      target_out;

   modport source (output valid, stage_out, heat_enable, pump_enable, pump_speed_out,
                   target_out, input ready);
   modport sink   (input valid, stage_out, heat_enable, pump_enable, pump_speed_out,
                   target_out, output ready);
endinterface

[rtl/core/mss_csr.sv]
// APB-style configuration registers: mash-in target and six stage settings.
// Depends on mss_pkg.
module mss_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mss_pkg::AddrW-1:0]     paddr,
   input  logic [mss_pkg::DataW-1:0]     pwdata,
   output logic [mss_pkg::DataW-1:0]     prdata,
   output logic                          pready,
   output mss_pkg::cfg_type              cfg
);

   logic [mss_pkg::DegW-1:0]                         mashin_ff, mashin_in;
   logic [mss_pkg::NumSets-1:0][mss_pkg::SetW-1:0]   setting_ff, setting_in;
   mss_pkg::reg_type                                 reg_idx;
   logic [mss_pkg::SetIdxW-1:0]                      set_idx;
   logic                                             wr_en;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = mss_pkg::reg_type'(paddr[mss_pkg::AddrW-1:2]);
   assign set_idx = mss_pkg::SetIdxW'(paddr[mss_pkg::AddrW-1:2]) - 3'd1;

   always_comb begin
      mashin_in  = mashin_ff;
      setting_in = setting_ff;
      if (wr_en && reg_idx == mss_pkg::REG_MASHIN) begin
         mashin_in = pwdata[mss_pkg::DegW-1:0];
      end else if (wr_en && reg_idx inside {[mss_pkg::REG_REST1:mss_pkg::REG_BOIL]}) begin
         setting_in[set_idx] = pwdata[mss_pkg::SetW-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == mss_pkg::REG_MASHIN) begin
         prdata = mss_pkg::DataW'(mashin_ff);
      end else if (reg_idx inside {[mss_pkg::REG_REST1:mss_pkg::REG_BOIL]}) begin
         prdata = mss_pkg::DataW'(setting_ff[set_idx]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mashin_ff  <= '0;
         setting_ff <= '0;
      end else begin
         mashin_ff  <= mashin_in;
         setting_ff <= setting_in;
      end
   end

   assign cfg.mashin_target = mashin_ff;
   assign cfg.setting       = setting_ff;

endmodule

[rtl/core/mss_seq.sv]
// Stage sequencer: schedule state registers and the per-sample update.
// Depends on mss_pkg.
module mss_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step_en,
   input  mss_pkg::item_type    item,
   input  mss_pkg::cfg_type     cfg,
   output mss_pkg::result_type  result
);

   mss_pkg::stage_type              stage_ff, stage_in;
   logic [mss_pkg::SecW-1:0]        deadline_ff, deadline_in;
   logic [mss_pkg::DegW-1:0]        target_ff, target_in;
   logic                            heat_on_ff, heat_on_in;
   logic                            pump_on_ff, pump_on_in;
   logic [mss_pkg::SpeedW-1:0]      speed_ff, speed_in;
   logic [mss_pkg::VentW-1:0]       vent_ff, vent_in;
   logic [mss_pkg::SecW-1:0]        start_ff, start_in;

   logic [mss_pkg::SetIdxW-1:0]     load_idx;
   logic [mss_pkg::SetW-1:0]        load_set;
   logic [mss_pkg::ProdW-1:0]       load_secs;
   logic [mss_pkg::SecW:0]          load_sum;
   logic [mss_pkg::SecW-1:0]        load_deadline;
   logic [mss_pkg::SecW:0]          now_x, start_x;
   logic                            pulse_win;
   logic signed [mss_pkg::TempW:0]  temp_x, thresh_x;
   logic                            do_load;

   always_comb begin
      case (stage_ff)
         mss_pkg::ST_GRAIN:   load_idx = mss_pkg::SET_REST1;
         mss_pkg::ST_REST1,
         mss_pkg::ST_REST2,
         mss_pkg::ST_REST3,
         mss_pkg::ST_REST4:   load_idx = mss_pkg::SetIdxW'(stage_ff - mss_pkg::ST_GRAIN);
         mss_pkg::ST_MASHOUT: load_idx = mss_pkg::SET_BOIL;
         default:             load_idx = mss_pkg::SET_REST1;
      endcase
   end

   // deadline = now + 60 * minutes, saturated
   assign load_set      = cfg.setting[load_idx];
   assign load_secs     = {mss_pkg::min_of(load_set), 6'b0}
                          - {4'b0, mss_pkg::min_of(load_set), 2'b0};
   assign load_sum      = {1'b0, item.now_seconds} + (mss_pkg::SecW+1)'(load_secs);
   assign load_deadline = load_sum[mss_pkg::SecW] ? mss_pkg::SecMax
                                                  : load_sum[mss_pkg::SecW-1:0];

   assign now_x     = {1'b0, item.now_seconds};
   assign start_x   = {1'b0, start_ff};
   assign pulse_win = (now_x < start_x + mss_pkg::PulseFirstEnd)
                      || ((now_x > start_x + mss_pkg::PulseSecondOpen)
                          && (now_x < start_x + mss_pkg::PulseSecondEnd));

   assign temp_x   = {item.kettle_temp[mss_pkg::TempW-1], item.kettle_temp};
   assign thresh_x = $signed({1'b0, target_ff, 4'b0});

   always_comb begin
      stage_in   = stage_ff;
      deadline_in = deadline_ff;
      target_in  = target_ff;
      heat_on_in = heat_on_ff;
      pump_on_in = pump_on_ff;
      speed_in   = speed_ff;
      vent_in    = vent_ff;
      start_in   = start_ff;
      do_load    = 1'b0;
      case (stage_ff)
         mss_pkg::ST_MASHIN: begin
            heat_on_in = 1'b1;
            if (pulse_win) begin
               if (!pump_on_ff) begin
                  pump_on_in = 1'b1;
                  speed_in   = mss_pkg::SpeedFull;
               end
            end else if (pump_on_ff) begin
               pump_on_in = 1'b0;
               speed_in   = mss_pkg::SpeedOff;
               if (vent_ff != mss_pkg::VentMax) begin
                  vent_in = vent_ff + 2'd1;
               end
            end
            if (temp_x >= thresh_x && item.water_ready && vent_in == mss_pkg::VentsNeeded) begin
               stage_in = mss_pkg::ST_GRAIN;
            end
         end
         mss_pkg::ST_GRAIN: begin
            if (item.water_ready && item.grain_added) begin
               do_load    = 1'b1;
               stage_in   = mss_pkg::ST_REST1;
               pump_on_in = 1'b1;
               speed_in   = mss_pkg::SpeedHalf;
            end
         end
         mss_pkg::ST_REST1,
         mss_pkg::ST_REST2,
         mss_pkg::ST_REST3,
         mss_pkg::ST_REST4: begin
            if (item.now_seconds >= deadline_ff) begin
               do_load    = 1'b1;
               heat_on_in = 1'b1;
               stage_in   = mss_pkg::stage_type'(stage_ff + 4'd1);
            end
         end
         mss_pkg::ST_MASHOUT: begin
            if (item.mashout_done) begin
               do_load    = 1'b1;
               heat_on_in = 1'b1;
               stage_in   = mss_pkg::ST_BOIL;
            end
         end
         mss_pkg::ST_BOIL: begin
            if (item.now_seconds < deadline_ff) begin
               pump_on_in = 1'b0;
               speed_in   = mss_pkg::SpeedFull;
            end else begin
               heat_on_in = 1'b0;
               stage_in   = mss_pkg::ST_DONE;
            end
         end
         mss_pkg::ST_DONE: begin
            heat_on_in = 1'b0;
            pump_on_in = 1'b0;
            speed_in   = mss_pkg::SpeedOff;
         end
         default: begin
            if (item.water_ready && cfg.mashin_target != '0
                && mss_pkg::deg_of(cfg.setting[mss_pkg::SET_REST1]) != '0
                && mss_pkg::min_of(cfg.setting[mss_pkg::SET_REST1]) != '0) begin
               target_in  = cfg.mashin_target;
               heat_on_in = 1'b1;
               start_in   = item.now_seconds;
               vent_in    = '0;
               stage_in   = mss_pkg::ST_MASHIN;
            end
         end
      endcase
      if (do_load) begin
         deadline_in = load_deadline;
         target_in   = mss_pkg::deg_of(load_set);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff    <= mss_pkg::ST_IDLE;
         deadline_ff <= '0;
         target_ff   <= '0;
         heat_on_ff  <= 1'b0;
         pump_on_ff  <= 1'b0;
         speed_ff    <= '0;
         vent_ff     <= '0;
         start_ff    <= '0;
      end else if (step_en) begin
         stage_ff    <= stage_in;
         deadline_ff <= deadline_in;
         target_ff   <= target_in;
         heat_on_ff  <= heat_on_in;
         pump_on_ff  <= pump_on_in;
         speed_ff    <= speed_in;
         vent_ff     <= vent_in;
         start_ff    <= start_in;
      end
   end

   assign result.stage_out      = stage_in;
   assign result.heat_enable    = heat_on_in;
   assign result.pump_enable    = pump_on_in;
   assign result.pump_speed_out = speed_in;
   assign result.target_out     = target_in;

   a_stage_steps_by_one: assert property (@(posedge clock) disable iff (reset)
      (step_en && stage_in != stage_ff) |=> (stage_ff == $past(stage_ff) + 4'd1))
      else $error("stage skipped or moved backward");

   a_idle_outputs_off: assert property (@(posedge clock) disable iff (reset)
      (stage_ff == mss_pkg::ST_IDLE) |-> (!heat_on_ff && !pump_on_ff))
      else $error("heater or pump on while idle");

   a_vent_only_mashin: assert property (@(posedge clock) disable iff (reset)
      (step_en && vent_in != vent_ff)
      |-> (stage_ff == mss_pkg::ST_MASHIN || stage_ff == mss_pkg::ST_IDLE))
      else $error("vent count changed outside mash-in");

endmodule

[rtl/core/mash_schedule_sequencer_core.sv]
// Mash schedule sequencer top level: sample register, sequencer, result
// register and configuration port. Depends on mss_pkg, mss_if, mss_csr, mss_seq.
//
// Each sample transaction yields exactly one result transaction carrying
// the stage, heater enable, pump enable, pump speed and temperature target
// as they stand after that sample. Throughput is one transaction per
// clock while rsp_chan.ready is not held low; an accepted sample passes
// through the sample register and then the result register, with the stage
// update done between them. Configuration writes take effect at the next
// sample and should be made only while no transaction is in flight.
module mash_schedule_sequencer_core (
   input  logic                          clock,
   input  logic                          reset,
   mss_req_if.sink                       req_chan,
   mss_rsp_if.source                     rsp_chan,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [mss_pkg::AddrW-1:0]     paddr,
   input  logic [mss_pkg::DataW-1:0]     pwdata,
   output logic [mss_pkg::DataW-1:0]     prdata,
   output logic                          pready
);

   mss_pkg::cfg_type     cfg;
   mss_pkg::item_type    item_ff, item_in;
   logic                 in_valid_ff, in_valid_in;
   mss_pkg::result_type  rsp_ff, rsp_in, result;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 req_take;
   logic                 advance;

   mss_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mss_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      item_in.now_seconds  = req_chan.now_seconds;
      item_in.kettle_temp  = req_chan.kettle_temp;
      item_in.water_ready  = req_chan.water_ready;
      item_in.grain_added  = req_chan.grain_added;
      item_in.mashout_done = req_chan.mashout_done;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      rsp_in = result;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_ff <= item_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.stage_out      = rsp_ff.stage_out;
   assign rsp_chan.heat_enable    = rsp_ff.heat_enable;
   assign rsp_chan.pump_enable    = rsp_ff.pump_enable;
   assign rsp_chan.pump_speed_out = rsp_ff.pump_speed_out;
   assign rsp_chan.target_out     = rsp_ff.target_out;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("processed transaction lost before result register");

   a_held_sample_kept: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(item_ff)))
      else $error("pending sample dropped or overwritten");

endmodule

[tb/mss_schedule_checker.sv]
// Scoreboard for the mash schedule sequencer: follows the register writes
// and the sample transactions, predicts each status result and compares it.
// Depends on mss_pkg and the channel interfaces in mss_if.
module mss_schedule_checker (
   input  logic                       clock,
   input  logic                       reset,
   mss_req_if                         req_mon,
   mss_rsp_if                         rsp_mon,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic                       pready,
   input  logic [mss_pkg::AddrW-1:0]  paddr,
   input  logic [mss_pkg::DataW-1:0]  pwdata,
   output int                         fail_count,
   output int                         pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned PulseOneEnd      = 5;
   localparam int unsigned PulseTwoOpen     = 10;
   localparam int unsigned PulseTwoEnd      = 15;
   localparam int unsigned SecondsPerMinute = 60;
   localparam int unsigned SecLimit         = (1 << mss_pkg::SecW) - 1;
   localparam int          TempScale        = 16;
   localparam int          RestOneSlot      = 0;
   localparam int          BoilSlot         = 5;
   localparam int          ReportLimit      = 10;
   localparam logic [mss_pkg::SpeedW-1:0] PumpFast  = 6'd60;
   localparam logic [mss_pkg::SpeedW-1:0] PumpSlow  = 6'd30;
   localparam logic [mss_pkg::SpeedW-1:0] PumpStop  = 6'd0;
   localparam logic [mss_pkg::VentW-1:0]  VentTop   = 2'd3;
   localparam logic [mss_pkg::VentW-1:0]  VentsToGo = 2'd2;

   logic [mss_pkg::DegW-1:0]   mashin_cfg;
   logic [mss_pkg::SetW-1:0]   settings [mss_pkg::NumSets];

   mss_pkg::stage_type         stage;
   logic [mss_pkg::SecW-1:0]   deadline;
   logic [mss_pkg::DegW-1:0]   target;
   logic                       heat_on;
   logic                       pump_on;
   logic [mss_pkg::SpeedW-1:0] speed;
   logic [mss_pkg::VentW-1:0]  vent_count;
   logic [mss_pkg::SecW-1:0]   pulse_start;

   mss_pkg::result_type        status_due [$];

   function automatic void arm_deadline(input int slot, input logic [mss_pkg::SecW-1:0] now);
      int unsigned sum;
      sum = int'(now) + SecondsPerMinute * settings[slot][mss_pkg::MinW-1:0];
      deadline = (sum > SecLimit) ? mss_pkg::SecW'(SecLimit) : mss_pkg::SecW'(sum);
      target = settings[slot][mss_pkg::SetW-1 -: mss_pkg::DegW];
   endfunction

   function automatic mss_pkg::result_type step_schedule(input mss_pkg::item_type it);
      int unsigned         now_v;
      int unsigned         start_v;
      int                  temp_v;
      logic                in_pulse;
      mss_pkg::result_type r;
      now_v   = it.now_seconds;
      start_v = pulse_start;
      temp_v  = int'($signed(it.kettle_temp));
      case (stage)
         mss_pkg::ST_MASHIN: begin
            in_pulse = (now_v < start_v + PulseOneEnd) ||
                       (now_v > start_v + PulseTwoOpen && now_v < start_v + PulseTwoEnd);
            heat_on = 1'b1;
            if (in_pulse) begin
               if (!pump_on) begin
                  pump_on = 1'b1;
                  speed = PumpFast;
               end
            end else if (pump_on) begin
               pump_on = 1'b0;
               speed = PumpStop;
               if (vent_count != VentTop) vent_count = vent_count + 1'b1;
            end
            if (temp_v >= int'(target) * TempScale && it.water_ready &&
                vent_count == VentsToGo) stage = mss_pkg::ST_GRAIN;
         end
         mss_pkg::ST_GRAIN: begin
            if (it.water_ready && it.grain_added) begin
               arm_deadline(RestOneSlot, it.now_seconds);
               stage = mss_pkg::ST_REST1;
               pump_on = 1'b1;
               speed = PumpSlow;
            end
         end
         mss_pkg::ST_REST1, mss_pkg::ST_REST2, mss_pkg::ST_REST3, mss_pkg::ST_REST4: begin
            if (it.now_seconds >= deadline) begin
               arm_deadline(int'(stage) - int'(mss_pkg::ST_REST1) + 1, it.now_seconds);
               heat_on = 1'b1;
               stage = mss_pkg::stage_type'(stage + 1'b1);
            end
         end
         mss_pkg::ST_MASHOUT: begin
            if (it.mashout_done) begin
               arm_deadline(BoilSlot, it.now_seconds);
               heat_on = 1'b1;
               stage = mss_pkg::ST_BOIL;
            end
         end
         mss_pkg::ST_BOIL: begin
            if (it.now_seconds < deadline) begin
               pump_on = 1'b0;
               speed = PumpFast;
            end else begin
               heat_on = 1'b0;
               stage = mss_pkg::ST_DONE;
            end
         end
         mss_pkg::ST_DONE: begin
            heat_on = 1'b0;
            pump_on = 1'b0;
            speed = PumpStop;
         end
         default: begin
            if (it.water_ready && mashin_cfg != '0 &&
                settings[RestOneSlot][mss_pkg::SetW-1 -: mss_pkg::DegW] != '0 &&
                settings[RestOneSlot][mss_pkg::MinW-1:0] != '0) begin
               target = mashin_cfg;
               heat_on = 1'b1;
               pulse_start = it.now_seconds;
               vent_count = '0;
               stage = mss_pkg::ST_MASHIN;
            end
         end
      endcase
      r.stage_out      = stage;
      r.heat_enable    = heat_on;
      r.pump_enable    = pump_on;
      r.pump_speed_out = speed;
      r.target_out     = target;
      return r;
   endfunction

   function automatic string show(input mss_pkg::result_type r);
      return $sformatf("stage %0d heat %0b pump %0b speed %0d target %0d", r.stage_out,
                       r.heat_enable, r.pump_enable, r.pump_speed_out, r.target_out);
   endfunction

   task automatic flag_error(input string what, input mss_pkg::result_type want,
                             input mss_pkg::result_type got);
      fail_count++;
      if (fail_count <= ReportLimit)
         $display("%0t: %s: expected %s, got %s", $realtime, what, show(want), show(got));
   endtask

   always @(posedge clock) begin
      mss_pkg::item_type   taken;
      mss_pkg::result_type seen;
      mss_pkg::result_type want;
      mss_pkg::reg_type    which;
      if (reset) begin
         mashin_cfg  = '0;
         foreach (settings[i]) settings[i] = '0;
         stage       = mss_pkg::ST_IDLE;
         deadline    = '0;
         target      = '0;
         heat_on     = 1'b0;
         pump_on     = 1'b0;
         speed       = PumpStop;
         vent_count  = '0;
         pulse_start = '0;
         status_due.delete();
         fail_count  = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.stage_out      = rsp_mon.stage_out;
            seen.heat_enable    = rsp_mon.heat_enable;
            seen.pump_enable    = rsp_mon.pump_enable;
            seen.pump_speed_out = rsp_mon.pump_speed_out;
            seen.target_out     = rsp_mon.target_out;
            if (status_due.size() == 0) begin
               flag_error("status with no sample outstanding", '0, seen);
            end else begin
               want = status_due.pop_front();
               if (seen.stage_out !== want.stage_out || seen.heat_enable !== want.heat_enable ||
                   seen.pump_enable !== want.pump_enable ||
                   seen.pump_speed_out !== want.pump_speed_out ||
                   seen.target_out !== want.target_out)
                  flag_error("status mismatch", want, seen);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            taken.now_seconds  = req_mon.now_seconds;
            taken.kettle_temp  = req_mon.kettle_temp;
            taken.water_ready  = req_mon.water_ready;
            taken.grain_added  = req_mon.grain_added;
            taken.mashout_done = req_mon.mashout_done;
            status_due.push_back(step_schedule(taken));
         end
         if (psel && penable && pwrite && pready) begin
            which = mss_pkg::reg_type'(paddr[mss_pkg::AddrW-1:2]);
            case (which)
               mss_pkg::REG_MASHIN: mashin_cfg = pwdata[mss_pkg::DegW-1:0];
               mss_pkg::REG_REST1, mss_pkg::REG_REST2, mss_pkg::REG_REST3,
               mss_pkg::REG_REST4, mss_pkg::REG_MASHOUT, mss_pkg::REG_BOIL:
                  settings[int'(which) - int'(mss_pkg::REG_REST1)] =
                     pwdata[mss_pkg::SetW-1:0];
               default: ;
            endcase
         end
      end
      pending = status_due.size();
   end

endmodule

[tb/mash_schedule_sequencer_core_tb.sv]
// Top of the mash schedule sequencer testbench: clock, reset, register writes
// and sample stimulus that walks one full brew, plus the final verdict.
// Depends on mss_pkg, mss_if, mss_schedule_checker and the core RTL.
module mash_schedule_sequencer_core_tb ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SecTop     = (1 << mss_pkg::SecW) - 1;
   localparam int unsigned NowTop     = 4294967;
   localparam int unsigned SecPerMin  = 60;
   localparam int          RegStride  = 4;
   localparam int          StallLimit = 1000;
   localparam int          TempLow    = -880;
   localparam int          TempHigh   = 2000;
   localparam int          TempScale  = 16;
   localparam int          TempTop    = 2047;

   logic                        clock;
   logic                        reset;
   logic                        psel;
   logic                        penable;
   logic                        pwrite;
   logic [mss_pkg::AddrW-1:0]   paddr;
   logic [mss_pkg::DataW-1:0]   pwdata;
   logic [mss_pkg::DataW-1:0]   prdata;
   logic                        pready;
   int                          fail_count;
   int                          pending;
   bit                          quiet;
   bit                          idle_on;
   int                          ready_hold;
   int                          idle_cycles;
   logic [mss_pkg::SetW-1:0]    reg_shadow [7];

   mss_req_if req_chan ();
   mss_rsp_if rsp_chan ();

   mash_schedule_sequencer_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mss_schedule_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(negedge clock) begin
      if (reset || quiet || !idle_on) begin
         ready_hold = 0;
         rsp_chan.ready <= 1'b1;
      end else begin
         if (ready_hold == 0 && $urandom_range(0, 5) == 0)
            ready_hold = $urandom_range(1, 3);
         rsp_chan.ready <= (ready_hold == 0);
         if (ready_hold > 0) ready_hold--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= StallLimit) begin
            $display("** mash_schedule_sequencer_core: FAILED **");
            $finish;
         end
      end
   end

   function automatic logic rbit();
      return 1'($urandom_range(0, 1));
   endfunction

   function automatic logic [mss_pkg::SecW-1:0] any_now();
      if ($urandom_range(0, 9) == 0) return mss_pkg::SecW'($urandom);
      return mss_pkg::SecW'($urandom_range(0, NowTop));
   endfunction

   function automatic logic signed [mss_pkg::TempW-1:0] any_temp();
      if ($urandom_range(0, 9) == 0) return mss_pkg::TempW'($urandom);
      return mss_pkg::TempW'(TempLow + int'($urandom_range(0, TempHigh - TempLow)));
   endfunction

   function automatic logic signed [mss_pkg::TempW-1:0] temp_below(
      input logic [mss_pkg::DegW-1:0] tgt);
      int hi;
      hi = int'(tgt) * TempScale - 1;
      return mss_pkg::TempW'(TempLow + int'($urandom_range(0, hi - TempLow)));
   endfunction

   function automatic logic signed [mss_pkg::TempW-1:0] temp_reached(
      input logic [mss_pkg::DegW-1:0] tgt);
      int lo;
      lo = int'(tgt) * TempScale;
      return mss_pkg::TempW'(lo + int'($urandom_range(0, TempTop - lo)));
   endfunction

   function automatic logic [mss_pkg::SetW-1:0] rest_word();
      logic [mss_pkg::MinW-1:0] minutes;
      case ($urandom_range(0, 3))
         0: minutes = '0;
         1, 2: minutes = mss_pkg::MinW'($urandom_range(1, 5));
         default: minutes = mss_pkg::MinW'($urandom_range(6, 255));
      endcase
      return {mss_pkg::DegW'($urandom), minutes};
   endfunction

   function automatic int unsigned due_time(input int unsigned start,
                                            input logic [mss_pkg::SetW-1:0] word);
      int unsigned sum;
      sum = start + SecPerMin * word[mss_pkg::MinW-1:0];
      return (sum > SecTop) ? SecTop : sum;
   endfunction

   task automatic mix();
      idle_on = ($urandom_range(0, 3) != 0);
   endtask

   task automatic feed(input logic [mss_pkg::SecW-1:0] now,
                       input logic signed [mss_pkg::TempW-1:0] temp,
                       input logic water, input logic grain, input logic mash_done);
      if (idle_on && !quiet && $urandom_range(0, 4) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.now_seconds  <= now;
      req_chan.kettle_temp  <= temp;
      req_chan.water_ready  <= water;
      req_chan.grain_added  <= grain;
      req_chan.mashout_done <= mash_done;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic put_reg(input mss_pkg::reg_type which,
                          input logic [mss_pkg::SetW-1:0] value);
      logic [mss_pkg::DataW-1:0] junk;
      junk = $urandom;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= mss_pkg::AddrW'(int'(which) * RegStride);
      if (which == mss_pkg::REG_MASHIN)
         pwdata <= {junk[mss_pkg::DataW-1:mss_pkg::DegW], value[mss_pkg::DegW-1:0]};
      else pwdata <= {junk[mss_pkg::DataW-1:mss_pkg::SetW], value};
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      reg_shadow[which] = (which == mss_pkg::REG_MASHIN) ?
                          mss_pkg::SetW'(value[mss_pkg::DegW-1:0]) : value;
   endtask

   task automatic idle_batch(input int count);
      repeat (count) feed(any_now(), any_temp(), rbit(), rbit(), rbit());
   endtask

   initial begin : stimulus
      int unsigned               s;
      int unsigned               t;
      int unsigned               due;
      int unsigned               span;
      logic [mss_pkg::DegW-1:0]  tgt;
      logic                      w;
      reset                 = 1'b1;
      quiet                 = 1'b0;
      idle_on               = 1'b1;
      psel                  = 1'b0;
      penable               = 1'b0;
      pwrite                = 1'b0;
      paddr                 = '0;
      pwdata                = '0;
      req_chan.valid        = 1'b0;
      req_chan.now_seconds  = '0;
      req_chan.kettle_temp  = '0;
      req_chan.water_ready  = 1'b0;
      req_chan.grain_added  = 1'b0;
      req_chan.mashout_done = 1'b0;
      rsp_chan.ready        = 1'b0;
      foreach (reg_shadow[i]) reg_shadow[i] = '0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // registers still zero: every sample must leave the sequencer idle
      feed('0, 12'sh800, 1'b1, 1'b1, 1'b1);
      feed(mss_pkg::SecW'(SecTop), 12'sh7FF, 1'b1, 1'b0, 1'b0);
      feed(mss_pkg::SecW'(NowTop), mss_pkg::TempW'(TempHigh), 1'b0, 1'b1, 1'b0);
      feed(mss_pkg::SecW'(1), mss_pkg::TempW'(TempLow), 1'b1, 1'b0, 1'b1);
      feed(23'h2AAAAA, 12'sh555, 1'b0, 1'b0, 1'b1);
      feed(23'h555555, 12'shAAA, 1'b1, 1'b1, 1'b0);
      feed('0, '0, 1'b0, 1'b0, 1'b0);
      feed(mss_pkg::SecW'(SecTop), 12'shFFF, 1'b1, 1'b1, 1'b1);

      // start blocked by zero rest 1 minutes, then zero degrees, then zero mash-in target
      settle();
      mix();
      put_reg(mss_pkg::REG_MASHIN, mss_pkg::SetW'(8'hFF));
      put_reg(mss_pkg::REG_REST1, 16'hFF00);
      put_reg(mss_pkg::REG_REST2, 16'hFFFF);
      put_reg(mss_pkg::REG_REST3, 16'hFFFF);
      put_reg(mss_pkg::REG_REST4, 16'hFFFF);
      put_reg(mss_pkg::REG_MASHOUT, 16'hFFFF);
      put_reg(mss_pkg::REG_BOIL, 16'hFFFF);
      idle_batch(30);
      settle();
      mix();
      put_reg(mss_pkg::REG_REST1, 16'h00FF);
      idle_batch(30);
      settle();
      mix();
      put_reg(mss_pkg::REG_MASHIN, '0);
      put_reg(mss_pkg::REG_REST1, 16'hFFFF);
      idle_batch(30);

      settle();
      mix();
      put_reg(mss_pkg::REG_MASHIN, mss_pkg::SetW'($urandom_range(20, 100)));
      put_reg(mss_pkg::REG_REST1, {mss_pkg::DegW'($urandom_range(1, 255)),
                                   mss_pkg::MinW'($urandom_range(1, 255))});
      put_reg(mss_pkg::REG_REST2, rest_word());
      put_reg(mss_pkg::REG_REST3, rest_word());
      put_reg(mss_pkg::REG_REST4, rest_word());
      put_reg(mss_pkg::REG_MASHOUT, rest_word());
      put_reg(mss_pkg::REG_BOIL, rest_word());
      tgt = reg_shadow[mss_pkg::REG_MASHIN][mss_pkg::DegW-1:0];
      repeat (30) feed(any_now(), any_temp(), 1'b0, rbit(), rbit());
      s = $urandom_range(100, 4000000);
      feed(mss_pkg::SecW'(s), any_temp(), 1'b1, rbit(), rbit());

      // mash-in: first pulse, gap, second pulse, then wait for temperature
      mix();
      repeat (60) feed(mss_pkg::SecW'(s - 20 + $urandom_range(0, 24)), any_temp(), rbit(),
                       rbit(), rbit());
      repeat (60) feed(mss_pkg::SecW'(s + $urandom_range(5, 10)), any_temp(), rbit(), rbit(),
                       rbit());
      mix();
      repeat (60) feed(mss_pkg::SecW'(s + $urandom_range(11, 14)), any_temp(), rbit(), rbit(),
                       rbit());
      repeat (110) begin
         w = rbit();
         feed(mss_pkg::SecW'(s + $urandom_range(15, 5000)), w ? temp_below(tgt) : any_temp(),
              w, rbit(), rbit());
      end
      t = s + $urandom_range(15, 5000);
      feed(mss_pkg::SecW'(t), temp_reached(tgt), 1'b1, rbit(), rbit());

      // grain acknowledge, with rest 1 rewritten just before it is used
      mix();
      repeat (50) begin
         w = rbit();
         feed(any_now(), any_temp(), w, w ? 1'b0 : rbit(), rbit());
      end
      settle();
      put_reg(mss_pkg::REG_REST1, rest_word());
      t = t + $urandom_range(0, 100);
      feed(mss_pkg::SecW'(t), any_temp(), 1'b1, 1'b1, rbit());
      due = due_time(t, reg_shadow[mss_pkg::REG_REST1]);

      for (int k = 0; k < 4; k++) begin
         mix();
         repeat (40) feed(mss_pkg::SecW'($urandom_range(t - 50, due - 1)), any_temp(), rbit(),
                          rbit(), rbit());
         if (k == 0) begin
            settle();
            put_reg(mss_pkg::REG_REST2, rest_word());
            put_reg(mss_pkg::REG_REST3, rest_word());
            put_reg(mss_pkg::REG_REST4, rest_word());
            put_reg(mss_pkg::REG_MASHOUT, rest_word());
         end
         repeat (40) feed(mss_pkg::SecW'($urandom_range(t - 50, due - 1)), any_temp(), rbit(),
                          rbit(), rbit());
         t = due + $urandom_range(0, 30);
         if (t > SecTop) t = SecTop;
         feed(mss_pkg::SecW'(t), any_temp(), rbit(), rbit(), rbit());
         due = due_time(t, reg_shadow[mss_pkg::reg_type'(int'(mss_pkg::REG_REST2) + k)]);
      end

      // mash-out, then a boil whose deadline runs past the top of the clock
      mix();
      repeat (60) feed(any_now(), any_temp(), rbit(), rbit(), 1'b0);
      settle();
      put_reg(mss_pkg::REG_BOIL, {mss_pkg::DegW'($urandom),
                                  mss_pkg::MinW'($urandom_range(1, 4))});
      span = SecPerMin * reg_shadow[mss_pkg::REG_BOIL][mss_pkg::MinW-1:0];
      t = SecTop - $urandom_range(0, span - 1);
      feed(mss_pkg::SecW'(t), any_temp(), rbit(), rbit(), 1'b1);
      mix();
      repeat (150) feed(mss_pkg::SecW'($urandom_range(0, SecTop - 1)), any_temp(), rbit(),
                        rbit(), rbit());
      feed(mss_pkg::SecW'(SecTop), any_temp(), rbit(), rbit(), rbit());

      mix();
      idle_batch(120);
      quiet = 1'b1;
      idle_batch(120);

      settle();
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("** mash_schedule_sequencer_core: PASSED **");
      end else begin
         $display("** mash_schedule_sequencer_core: FAILED **");
      end
      $finish;
   end

endmodule

[mash_schedule_sequencer_core.f]
rtl/core/mss_pkg.sv
rtl/core/mss_if.sv
rtl/core/mss_csr.sv
rtl/core/mss_seq.sv
rtl/core/mash_schedule_sequencer_core.sv
tb/mss_schedule_checker.sv
tb/mash_schedule_sequencer_core_tb.sv
